FILE: rtl/notch_filter_with_jitter_histogram_core_defines.svh
// Assertion macros for the notch filter / jitter histogram core.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef NOTCH_FILTER_WITH_JITTER_HISTOGRAM_CORE_DEFINES_SVH
`define NOTCH_FILTER_WITH_JITTER_HISTOGRAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define NFJH_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nfjh: same-cycle check failed");
// Next-cycle implication
`define NFJH_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nfjh: next-cycle check failed");
`else
`define NFJH_ASSERT_IMP(lbl, ante, cons)
`define NFJH_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/nfjh_pkg.sv
package nfjh_pkg;

   // Field widths
   localparam int SAMPLE_W   = 10;
   localparam int TS_W       = 32;
   localparam int COUNT_W    = 20;
   localparam int PERIOD_W   = 32;
   localparam int FILT_W     = 16;
   localparam int JIT_W      = 32;
   localparam int IDX_W      = 6;
   localparam int BIN_CNT_W  = 32;

   // Configuration port
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXPECTED_PERIOD = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RUN_LENGTH      = 1'b1;

   // Register reset values
   localparam logic [PERIOD_W-1:0] EXPECTED_PERIOD_RESET = PERIOD_W'(100000 / 50);
   localparam logic [COUNT_W-1:0]  RUN_LENGTH_RESET      = COUNT_W'(10000);
   localparam logic signed [JIT_W-1:0] MIN_SEEN_RESET    = JIT_W'(10000000);

   // Default sizes
   localparam int HIST_BINS_DEF = 64;
   localparam int MID_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF = 4;

   // Notch filter arithmetic: Q8 coefficients, accumulator fits in 27 bits
   localparam int ACC_W  = 28;
   localparam int FRAC_W = 8;
   localparam logic signed [ACC_W-1:0] COEF_X1 = ACC_W'(503);
   localparam logic signed [ACC_W-1:0] COEF_Y1 = ACC_W'(498);
   localparam logic signed [ACC_W-1:0] COEF_Y2 = ACC_W'(251);
   localparam logic signed [ACC_W-1:0] ROUND_K = ACC_W'(128);

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [TS_W-1:0]     timestamp;
      logic [COUNT_W-1:0]  samples_so_far;
   } req_item_type;

   typedef struct packed {
      logic                     processed;
      logic signed [FILT_W-1:0] filtered;
      logic                     jitter_valid;
      logic signed [JIT_W-1:0]  jitter;
      logic signed [JIT_W-1:0]  max_jitter;
      logic signed [JIT_W-1:0]  min_jitter;
      logic [IDX_W-1:0]         bin_index;
      logic [BIN_CNT_W-1:0]     bin_count;
   } rsp_item_type;

   // Item handed from the front end to the histogram back end
   typedef struct packed {
      logic                     processed;
      logic signed [FILT_W-1:0] filtered;
      logic                     jitter_valid;
      logic signed [JIT_W-1:0]  jitter;
      logic signed [JIT_W-1:0]  max_jitter;
      logic signed [JIT_W-1:0]  min_jitter;
   } mid_item_type;

endpackage

FILE: rtl/notch_filter_with_jitter_histogram_core.sv
// Notch filter with sample-timing jitter histogram.
// Input channel (req_): push an item of sample, timestamp and running sample
// count while req_full is low. Result channel (rsp_): one result item per
// input item, in order; the oldest result sits on rsp_item while rsp_empty is
// low and leaves on rsp_pop. Items whose count is at or past run_length give
// an all-zero result and change no state.
// Configuration (csr_): index 0 is expected_period, index 1 is run_length;
// write only while no item is in flight.
// Path: front stage register, inner item queue, back-end stage register, then
// the result queue. Throughput: one item per cycle while req_full is low; the
// filter feedback and histogram read-modify-write (write forwarding) keep pace.
// Reset: filter history, extremes and registers return to defaults, then the
// HIST_BINS-entry bin table is swept to zero, entry by entry, with req_full high.
// Stall: when rsp_pop stays low, the result queue, then the inner item queue
// fill up and req_full rises; nothing is dropped.
`include "notch_filter_with_jitter_histogram_core_defines.svh"

module notch_filter_with_jitter_histogram_core #(
   parameter int HIST_BINS = nfjh_pkg::HIST_BINS_DEF,
   parameter int MID_DEPTH = nfjh_pkg::MID_DEPTH_DEF,
   parameter int OUT_DEPTH = nfjh_pkg::OUT_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  nfjh_pkg::req_item_type            req_item,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output nfjh_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_wr_en,
   input  logic [nfjh_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [nfjh_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import nfjh_pkg::*;

   localparam int MCW = $clog2(MID_DEPTH + 1);
   localparam int OCW = $clog2(OUT_DEPTH + 1);
   localparam int MID_W = $bits(mid_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

   logic [PERIOD_W-1:0] period_ff;
   logic [COUNT_W-1:0]  run_len_ff;

   logic               in_accept;
   logic               front_full;
   logic               clearing;
   logic               mid_push, mid_pop, mid_empty, mid_full;
   logic [MCW-1:0]     mid_count;
   mid_item_type       front_item;
   logic [MID_W-1:0]   mid_data;
   logic               out_push, out_full, out_empty;
   logic [OCW-1:0]     out_count;
   rsp_item_type       back_item;
   logic [RSP_W-1:0]   out_data;

   assign req_full  = front_full || clearing;
   assign in_accept = req_push && !req_full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= EXPECTED_PERIOD_RESET;
         run_len_ff <= RUN_LENGTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_EXPECTED_PERIOD: period_ff  <= csr_wdata[PERIOD_W-1:0];
            CSR_RUN_LENGTH:      run_len_ff <= csr_wdata[COUNT_W-1:0];
            default:             ;
         endcase
      end
   end

   nfjh_front #(
      .MID_DEPTH (MID_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_accept       (in_accept),
      .req_item        (req_item),
      .expected_period (period_ff),
      .run_length      (run_len_ff),
      .mid_count       (mid_count),
      .full            (front_full),
      .mid_push        (mid_push),
      .mid_item        (front_item)
   );

   nfjh_fifo #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (MID_W'(front_item)),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .count     (mid_count),
      .empty     (mid_empty),
      .full      (mid_full)
   );

   nfjh_back #(
      .HIST_BINS (HIST_BINS),
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mid_item_type'(mid_data)),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_item  (back_item),
      .clearing  (clearing)
   );

   nfjh_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (RSP_W'(back_item)),
      .pop       (rsp_pop),
      .pop_data  (out_data),
      .count     (out_count),
      .empty     (out_empty),
      .full      (out_full)
   );

   assign rsp_empty = out_empty;
   assign rsp_item  = rsp_item_type'(out_data);

   // Flow control between the parts never drops or invents an item
   `NFJH_ASSERT_IMP(a_mid_no_overflow, mid_push, !mid_full)
   `NFJH_ASSERT_IMP(a_out_no_overflow, out_push, !out_full)
   `NFJH_ASSERT_IMP(a_mid_no_underflow, mid_pop, !mid_empty)
   // The clearing sweep runs once after reset
   `NFJH_ASSERT_NXT(a_clear_once, !clearing, !clearing)
endmodule

FILE: rtl/nfjh_ram.sv
module nfjh_ram #(
   parameter int WIDTH = nfjh_pkg::BIN_CNT_W,
   parameter int DEPTH = nfjh_pkg::HIST_BINS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port, one registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

FILE: rtl/nfjh_fifo.sv
module nfjh_fifo #(
   parameter int WIDTH = $bits(nfjh_pkg::mid_item_type),
   parameter int DEPTH = nfjh_pkg::MID_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic                       empty,
   output logic                       full
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign count    = count_ff;
   assign pop_data = data_ff[rd_ptr_ff];
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push_ok) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

FILE: rtl/nfjh_front.sv
module nfjh_front #(
   parameter int MID_DEPTH = nfjh_pkg::MID_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_accept,
   input  nfjh_pkg::req_item_type              req_item,
   input  logic [nfjh_pkg::PERIOD_W-1:0]       expected_period,
   input  logic [nfjh_pkg::COUNT_W-1:0]        run_length,
   input  logic [$clog2(MID_DEPTH+1)-1:0]      mid_count,
   output logic                                full,
   output logic                                mid_push,
   output nfjh_pkg::mid_item_type              mid_item
);
   import nfjh_pkg::*;

   localparam int CW = $clog2(MID_DEPTH + 1);

   // Filter history
   logic [SAMPLE_W-1:0]      x1_ff, x2_ff;
   logic signed [FILT_W-1:0] y1_ff, y2_ff;
   // Jitter tracking
   logic                     seen_ff;
   logic [TS_W-1:0]          last_ts_ff;
   logic signed [JIT_W-1:0]  max_ff, max_in;
   logic signed [JIT_W-1:0]  min_ff, min_in;
   // Stage between filter and min/max
   logic                     p_valid_ff;
   logic                     p_proc_ff;
   logic signed [FILT_W-1:0] p_filt_ff;
   logic                     p_jv_ff;
   logic signed [JIT_W-1:0]  p_jit_ff;

   logic                     proc;
   logic signed [ACC_W-1:0]  x0_e, x1_e, x2_e, y1_e, y2_e;
   logic signed [ACC_W-1:0]  acc, quo;
   logic signed [FILT_W-1:0] y_new;
   logic [JIT_W-1:0]         diff;
   logic                     upd_jit;

   assign proc = (req_item.samples_so_far < run_length);

   // Notch filter: Q8 sum, divide by 256 rounding toward zero, wrap to 16 bits
   always_comb begin
      x0_e = $signed(ACC_W'(req_item.sample));
      x1_e = $signed(ACC_W'(x1_ff));
      x2_e = $signed(ACC_W'(x2_ff));
      y1_e = ACC_W'(y1_ff);
      y2_e = ACC_W'(y2_ff);
      acc  = ((x0_e + x2_e) <<< FRAC_W) - COEF_X1 * x1_e + COEF_Y1 * y1_e
             - COEF_Y2 * y2_e + ROUND_K;
      quo  = acc >>> FRAC_W;
      if (acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0)) begin
         quo = quo + ACC_W'(1);
      end
      y_new = quo[FILT_W-1:0];
   end

   // Timestamp difference minus nominal period, modulo 2^32
   assign diff = req_item.timestamp - last_ts_ff - expected_period;

   // Running extremes
   assign upd_jit = p_valid_ff && p_jv_ff;
   assign max_in  = (upd_jit && (p_jit_ff > max_ff)) ? p_jit_ff : max_ff;
   assign min_in  = (upd_jit && (p_jit_ff < min_ff)) ? p_jit_ff : min_ff;

   // Hand-off to the queue
   assign mid_push              = p_valid_ff;
   assign mid_item.processed    = p_proc_ff;
   assign mid_item.filtered     = p_filt_ff;
   assign mid_item.jitter_valid = p_jv_ff;
   assign mid_item.jitter       = p_jit_ff;
   assign mid_item.max_jitter   = p_jv_ff ? max_in : '0;
   assign mid_item.min_jitter   = p_jv_ff ? min_in : '0;

   // Hold off while the queue could not take the item in flight
   assign full = ((CW + 1)'(mid_count) + (CW + 1)'(p_valid_ff)) >= (CW + 1)'(MID_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff      <= '0;
         x2_ff      <= '0;
         y1_ff      <= '0;
         y2_ff      <= '0;
         seen_ff    <= 1'b0;
         last_ts_ff <= '0;
         max_ff     <= '0;
         min_ff     <= MIN_SEEN_RESET;
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_accept;
         max_ff     <= max_in;
         min_ff     <= min_in;
         if (in_accept && proc) begin
            x2_ff      <= x1_ff;
            x1_ff      <= req_item.sample;
            y2_ff      <= y1_ff;
            y1_ff      <= y_new;
            seen_ff    <= 1'b1;
            last_ts_ff <= req_item.timestamp;
         end
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (in_accept) begin
         p_proc_ff <= proc;
         p_filt_ff <= proc ? y_new : '0;
         p_jv_ff   <= proc && seen_ff;
         p_jit_ff  <= (proc && seen_ff) ? $signed(diff) : '0;
      end
   end
endmodule

FILE: rtl/nfjh_back.sv
module nfjh_back #(
   parameter int HIST_BINS = nfjh_pkg::HIST_BINS_DEF,
   parameter int OUT_DEPTH = nfjh_pkg::OUT_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               mid_empty,
   input  nfjh_pkg::mid_item_type             mid_item,
   output logic                               mid_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
   output logic                               out_push,
   output nfjh_pkg::rsp_item_type             out_item,
   output logic                               clearing
);
   import nfjh_pkg::*;

   localparam int AW   = $clog2(HIST_BINS);
   localparam int HALF = HIST_BINS / 2;
   localparam int OCW  = $clog2(OUT_DEPTH + 1);

   logic                  clearing_ff;
   logic [AW-1:0]         clr_ff;
   logic                  a_valid_ff;
   mid_item_type          a_item_ff;
   logic [AW-1:0]         a_bin_ff;
   logic                  fw_valid_ff;
   logic [AW-1:0]         fw_addr_ff;
   logic [BIN_CNT_W-1:0]  fw_data_ff;

   logic signed [JIT_W:0] idx_s;
   logic [AW-1:0]         bin;
   logic                  room;
   logic [BIN_CNT_W-1:0]  rd_data, old_cnt, new_cnt;
   logic                  a_inc;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [BIN_CNT_W-1:0]  wr_data;

   assign clearing = clearing_ff;

   // Bin select: jitter plus half the bins, clamped to the table
   always_comb begin
      idx_s = $signed({mid_item.jitter[JIT_W-1], mid_item.jitter})
              + $signed((JIT_W + 1)'(HALF));
      if (idx_s[JIT_W]) begin
         bin = '0;
      end else if (idx_s >= $signed((JIT_W + 1)'(HIST_BINS))) begin
         bin = AW'(HIST_BINS - 1);
      end else begin
         bin = idx_s[AW-1:0];
      end
   end

   // Take an item only when the result queue has a slot for it
   assign room    = ((OCW + 1)'(out_count) + (OCW + 1)'(a_valid_ff)) < (OCW + 1)'(OUT_DEPTH);
   assign mid_pop = !mid_empty && !clearing_ff && room;

   // Read-modify-write with forwarding of last cycle's write
   assign old_cnt = (fw_valid_ff && (fw_addr_ff == a_bin_ff)) ? fw_data_ff : rd_data;
   assign new_cnt = (&old_cnt) ? old_cnt : old_cnt + 1'b1;
   assign a_inc   = a_valid_ff && a_item_ff.jitter_valid;

   // Write port: clearing sweep after reset, else the bin update
   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = a_inc;
         wr_addr = a_bin_ff;
         wr_data = new_cnt;
      end
   end

   nfjh_ram #(
      .WIDTH (BIN_CNT_W),
      .DEPTH (HIST_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (mid_pop),
      .rd_addr (bin),
      .rd_data (rd_data)
   );

   // Result item
   assign out_push               = a_valid_ff;
   assign out_item.processed     = a_item_ff.processed;
   assign out_item.filtered      = a_item_ff.filtered;
   assign out_item.jitter_valid  = a_item_ff.jitter_valid;
   assign out_item.jitter        = a_item_ff.jitter;
   assign out_item.max_jitter    = a_item_ff.max_jitter;
   assign out_item.min_jitter    = a_item_ff.min_jitter;
   assign out_item.bin_index     = a_item_ff.jitter_valid ? IDX_W'(a_bin_ff) : '0;
   assign out_item.bin_count     = a_item_ff.jitter_valid ? new_cnt : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
         a_valid_ff  <= 1'b0;
         fw_valid_ff <= 1'b0;
      end else begin
         a_valid_ff  <= mid_pop;
         fw_valid_ff <= a_inc && !clearing_ff;
         if (clearing_ff) begin
            if (clr_ff == AW'(HIST_BINS - 1)) begin
               clearing_ff <= 1'b0;
            end else begin
               clr_ff <= clr_ff + 1'b1;
            end
         end
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (mid_pop) begin
         a_item_ff <= mid_item;
         a_bin_ff  <= bin;
      end
      fw_addr_ff <= a_bin_ff;
      fw_data_ff <= new_cnt;
   end
endmodule

FILE: sim/tb.sv
module tb;
   import nfjh_pkg::*;

   localparam int HALF_BINS   = HIST_BINS_DEF / 2;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 100;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_push;
   logic                    req_full;
   req_item_type            req_item;
   logic                    rsp_empty;
   logic                    rsp_pop;
   rsp_item_type            rsp_item;
   logic                    csr_wr_en;
   logic [CSR_ADDR_W-1:0]   csr_addr;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   notch_filter_with_jitter_histogram_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of registers and block state
   logic [PERIOD_W-1:0]      period_cfg;
   logic [COUNT_W-1:0]       run_cfg;
   logic signed [FILT_W-1:0] x_hist [2];
   logic signed [FILT_W-1:0] y_hist [2];
   logic [31:0]              done_count;
   logic [TS_W-1:0]          last_stamp;
   logic signed [JIT_W-1:0]  max_seen;
   logic signed [JIT_W-1:0]  min_seen;
   logic [BIN_CNT_W-1:0]     bin_counts [HIST_BINS_DEF];

   rsp_item_type expected_results [$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           pop_wait = 0;
   bit           steady;
   bit           toggle;
   logic [TS_W-1:0] stamp;

   function void clear_predictor();
      period_cfg = EXPECTED_PERIOD_RESET;
      run_cfg    = RUN_LENGTH_RESET;
      x_hist[0]  = '0;
      x_hist[1]  = '0;
      y_hist[0]  = '0;
      y_hist[1]  = '0;
      done_count = '0;
      last_stamp = '0;
      max_seen   = '0;
      min_seen   = MIN_SEEN_RESET;
      foreach (bin_counts[i]) bin_counts[i] = '0;
   endfunction

   // Notch filter step followed by jitter tracking and histogram update
   function rsp_item_type notch_and_histogram_step(input req_item_type it);
      rsp_item_type        r;
      longint              acc;
      longint              quot;
      longint              idx;
      logic [TS_W-1:0]     diff;
      logic signed [31:0]  jit;
      logic [IDX_W-1:0]    bin;
      r = '0;
      if (it.samples_so_far >= run_cfg) return r;

      acc = 256 * (longint'(it.sample) + longint'(x_hist[1]))
            - 503 * longint'(x_hist[0]) + 498 * longint'(y_hist[0])
            - 251 * longint'(y_hist[1]) + 128;
      quot = acc / 256;   // truncates toward zero
      x_hist[1] = x_hist[0];
      x_hist[0] = FILT_W'(it.sample);
      y_hist[1] = y_hist[0];
      y_hist[0] = quot[FILT_W-1:0];
      r.processed = 1'b1;
      r.filtered  = quot[FILT_W-1:0];

      if (done_count != '1) done_count++;
      if (done_count > 1) begin
         diff = it.timestamp - last_stamp - period_cfg;
         jit  = diff;
         if (jit > max_seen) max_seen = jit;
         if (jit < min_seen) min_seen = jit;
         idx = longint'(jit) + HALF_BINS;
         if (idx < 0) idx = 0;
         if (idx >= HIST_BINS_DEF) idx = HIST_BINS_DEF - 1;
         bin = idx[IDX_W-1:0];
         if (bin_counts[bin] != '1) bin_counts[bin]++;
         r.jitter_valid = 1'b1;
         r.jitter       = jit;
         r.max_jitter   = max_seen;
         r.min_jitter   = min_seen;
         r.bin_index    = bin;
         r.bin_count    = bin_counts[bin];
      end
      last_stamp = it.timestamp;
      return r;
   endfunction

   task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endtask

   task check_result(input rsp_item_type got);
      rsp_item_type want;
      if (expected_results.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected item, expected none, got %h", $time, got);
      end else begin
         want = expected_results.pop_front();
         check_field("processed", want.processed, got.processed);
         check_field("filtered", want.filtered, got.filtered);
         check_field("jitter_valid", want.jitter_valid, got.jitter_valid);
         check_field("jitter", want.jitter, got.jitter);
         check_field("max_jitter", want.max_jitter, got.max_jitter);
         check_field("min_jitter", want.min_jitter, got.min_jitter);
         check_field("bin_index", want.bin_index, got.bin_index);
         check_field("bin_count", want.bin_count, got.bin_count);
      end
   endtask

   // Result side: check each popped item, then draw the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_result(rsp_item);
            pop_wait = steady ? 0 : $urandom_range(0, 18);
         end
         if (pop_wait > 0) begin
            pop_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL notch_filter_with_jitter_histogram_core");
         $finish;
      end
   end

   // Send one item after a random gap; record its expected result on accept
   task send_item(input req_item_type it);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      if (it.samples_so_far < run_cfg) stamp = it.timestamp;
      expected_results.push_back(notch_and_histogram_step(it));
   endtask

   // Stop sending and let every outstanding item come back
   task drain_results();
      req_push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task write_config(input logic [PERIOD_W-1:0] period, input logic [COUNT_W-1:0] run_len);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_addr  <= CSR_EXPECTED_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_addr  <= CSR_RUN_LENGTH;
      csr_wdata <= CSR_DATA_W'(run_len);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      period_cfg = period;
      run_cfg    = run_len;
   endtask

   function req_item_type item_of(input logic [SAMPLE_W-1:0] s, input logic [TS_W-1:0] ts,
                                  input logic [COUNT_W-1:0] cnt);
      req_item_type it;
      it.sample         = s;
      it.timestamp      = ts;
      it.samples_so_far = cnt;
      return it;
   endfunction

   // First sample, min/max reset values, both clamp ends and the center bin
   task test_first_measurements();
      send_item(item_of(10'd0, 32'd1000, 20'd0));
      send_item(item_of(10'd1023, stamp + period_cfg + 32'd20000000, 20'd1));
      send_item(item_of(10'd1023, stamp + period_cfg - 32'd40, 20'd2));
      send_item(item_of(10'd0, stamp + period_cfg + 32'd31, 20'd3));
      send_item(item_of(10'd512, stamp + period_cfg + 32'd40, 20'd4));
      send_item(item_of(10'd1023, stamp + period_cfg, 20'd5));
      send_item(item_of(10'd1, stamp + period_cfg - 32'd32, RUN_LENGTH_RESET - 1));
   endtask

   // Counts at and past the run length, run length zero and maximum
   task test_run_limit();
      send_item(item_of(10'd700, stamp + period_cfg, RUN_LENGTH_RESET));
      send_item(item_of(10'd1023, 32'hFFFF_FFFF, COUNT_MAX));
      write_config(EXPECTED_PERIOD_RESET, '0);
      send_item(item_of(10'd300, stamp + period_cfg, 20'd0));
      write_config(EXPECTED_PERIOD_RESET, COUNT_MAX);
      send_item(item_of(10'd511, stamp + period_cfg + 32'd3, COUNT_MAX - 1));
      send_item(item_of(10'd1023, stamp + period_cfg, COUNT_MAX));
   endtask

   // Period extremes, jitter extremes and timestamp wrap
   task test_period_extremes();
      write_config('0, COUNT_MAX);
      send_item(item_of(10'd5, stamp + 32'd5, 20'd10));
      send_item(item_of(10'd1000, stamp + 32'h7FFF_FFFF, 20'd11));
      send_item(item_of(10'd20, stamp + 32'h8000_0000, 20'd12));
      write_config('1, RUN_LENGTH_RESET);
      send_item(item_of(10'd1023, 32'hFFFF_FF00, 20'd13));
      send_item(item_of(10'd0, stamp + period_cfg + 32'd10, 20'd14));
      send_item(item_of(10'd1023, stamp + period_cfg - 32'd1, 20'd15));
   endtask

   function req_item_type random_item();
      req_item_type it;
      int           pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         it.sample = SAMPLE_W'($urandom_range(0, 1023));
      end else if (pick < 8) begin
         toggle    = !toggle;
         it.sample = toggle ? 10'd1023 : 10'd0;
      end else begin
         it.sample = $urandom_range(0, 1) ? 10'(1023 - $urandom_range(0, 3))
                                           : 10'($urandom_range(0, 3));
      end

      pick = $urandom_range(0, 19);
      if (pick < 16)
         it.timestamp = stamp + period_cfg + 32'($urandom_range(0, 80)) - 32'd40;
      else if (pick < 18)
         it.timestamp = stamp + period_cfg + 32'($urandom_range(0, 4000)) - 32'd2000;
      else
         it.timestamp = $urandom;

      // mostly counts inside the run, some at or past its end
      pick = $urandom_range(0, 19);
      if (run_cfg != 0 && pick < 17)
         it.samples_so_far = COUNT_W'($urandom_range(0, run_cfg - 1));
      else if (pick < 19)
         it.samples_so_far = COUNT_W'($urandom_range(0, COUNT_MAX));
      else
         it.samples_so_far = run_cfg;
      return it;
   endfunction

   // Random streams under a series of register settings
   task test_random_phases();
      logic [PERIOD_W-1:0] period;
      logic [COUNT_W-1:0]  run_len;
      for (int ph = 0; ph < 10; ph++) begin
         case (ph % 5)
            0: begin period = EXPECTED_PERIOD_RESET; run_len = RUN_LENGTH_RESET; end
            1: begin period = '0;                    run_len = COUNT_MAX;        end
            2: begin period = '1; run_len = COUNT_W'($urandom_range(1, 64)); end
            3: begin period = $urandom; run_len = COUNT_W'($urandom_range(1, COUNT_MAX)); end
            default: begin period = $urandom_range(0, 5000); run_len = COUNT_MAX - 1; end
         endcase
         write_config(period, run_len);
         steady = ($urandom_range(0, 3) == 0);
         repeat (190) send_item(random_item());
         steady = 1'b0;
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_item  <= '0;
      csr_wr_en <= 1'b0;
      csr_addr  <= CSR_EXPECTED_PERIOD;
      csr_wdata <= '0;
      steady         = 1'b0;
      toggle         = 1'b0;
      stamp          = '0;
      clear_predictor();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_first_measurements();
      test_run_limit();
      test_period_extremes();
      test_random_phases();

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS notch_filter_with_jitter_histogram_core");
      else
         $display("FAIL notch_filter_with_jitter_histogram_core");
      $finish;
   end

endmodule
